// File: hw/rtl/rlpd_pkg.sv
// Shared types, codes and constants of the RLP stream decoder.
`timescale 1ns / 1ps

package rlpd_pkg;

    // Default sizing of the decoder.
    localparam int MAX_DEPTH_DEF = 8;
    localparam int LEN_BITS_DEF  = 32;

    // Results a single byte may cause; later ones are dropped.
    localparam int MAX_RES = 10;

    // Entries of the record queue between the front and the back.
    localparam int Q_DEPTH = 4;

    // Prefix byte boundaries.
    localparam logic [7:0] BYTE_MAX       = 8'h7F;
    localparam logic [7:0] STR_BASE       = 8'h80;
    localparam logic [7:0] STR_SHORT_MAX  = 8'hB7;
    localparam logic [7:0] STR_LONG_MAX   = 8'hBF;
    localparam logic [7:0] LIST_BASE      = 8'hC0;
    localparam logic [7:0] LIST_SHORT_MAX = 8'hF7;

    typedef enum logic [2:0] {
        K_SINGLE     = 3'd0,
        K_STR_START  = 3'd1,
        K_LEN_BYTE   = 3'd2,
        K_PAYLOAD    = 3'd3,
        K_LIST_START = 3'd4,
        K_LIST_END   = 3'd5,
        K_TRAILING   = 3'd6,
        K_ERROR      = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_OVERRUN  = 3'd2,
        ERR_WIDE     = 3'd3,
        ERR_DEEP     = 3'd4,
        ERR_EMPTY    = 3'd5
    } t_err;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_DONE    = 3'd3,
        PH_ABSORB  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        FS_IDLE  = 3'd0,
        FS_TOK   = 3'd1,
        FS_START = 3'd2,
        FS_ERR   = 3'd3,
        FS_POP   = 3'd4,
        FS_LOAD  = 3'd5,
        FS_TAIL  = 3'd6,
        FS_END   = 3'd7
    } t_fstate;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_value;
        logic [3:0]  nest_depth;
        logic [31:0] item_length;
        t_err        error_code;
        logic        frame_done;
        logic        last_result;
    } t_out_item;

    // Queue record: a result, or the marker that closes one byte's results.
    typedef struct packed {
        logic      step_end;
        logic      done;
        t_out_item item;
    } t_op;

endpackage

// File: hw/rtl/rlp_stream_decoder.sv
// RLP stream decoder top level: front sequencer, record queue and output back end.
// A byte holds the front through token, start and error states, a pop and load pass per
// list closed at it on return to a prefix, then tail and end; a full queue stalls it more.
// Synchronous active-low reset returns to expecting a prefix with no open lists;
// the list end stack is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module rlp_stream_decoder #(
    parameter int MAX_DEPTH = rlpd_pkg::MAX_DEPTH_DEF,
    parameter int LEN_BITS  = rlpd_pkg::LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rlpd_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output rlpd_pkg::t_out_item o_data
);

    logic          q_wr;
    rlpd_pkg::t_op q_wdata;
    logic          q_full;
    logic          q_rd;
    rlpd_pkg::t_op q_rdata;
    logic          q_empty;

    rlpd_front #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata),
        .i_q_full (q_full)
    );

    rlpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    rlpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    // The front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> !q_full)
        else $error("record written into full queue");

    // The back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("record read from empty queue");

    // A transfer keeps the front busy in the next cycle
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("front took a byte without working it off");

    // Error results carry a code and never mark a completed frame
    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.kind == rlpd_pkg::K_ERROR)) |->
        (o_data.error_code != rlpd_pkg::ERR_NONE) && !o_data.frame_done)
        else $error("error result without code or with frame done");

endmodule

// File: hw/rtl/rlpd_front.sv
// Front of the RLP decoder: takes bytes, classifies them and sequences result records.
`timescale 1ns / 1ps

module rlpd_front #(
    parameter int MAX_DEPTH = rlpd_pkg::MAX_DEPTH_DEF,
    parameter int LEN_BITS  = rlpd_pkg::LEN_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rlpd_pkg::t_in_item i_data,
    output logic               o_q_wr,
    output rlpd_pkg::t_op      o_q_data,
    input  logic               i_q_full
);

    localparam int OW     = $clog2(MAX_DEPTH + 1);
    localparam int AW     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW     = $clog2(rlpd_pkg::MAX_RES + 1);
    localparam int LL_MAX = LEN_BITS / 8;
    localparam logic [LEN_BITS-1:0] POS_MAX = '1;

    // Decoder state
    rlpd_pkg::t_fstate     r_state, n_state;
    rlpd_pkg::t_phase      r_phase, n_phase;
    logic                  r_is_list, n_is_list;
    logic [3:0]            r_len_left, n_len_left;
    logic [LEN_BITS-1:0]   r_acc, n_acc;
    logic [LEN_BITS-1:0]   r_str_end, n_str_end;
    logic [LEN_BITS-1:0]   r_pos, n_pos;
    logic [OW-1:0]         r_open, n_open;
    logic [LEN_BITS-1:0]   r_top, n_top;

    // End positions of open lists
    logic [LEN_BITS-1:0]   r_stack [MAX_DEPTH];
    logic [LEN_BITS-1:0]   r_rd;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic                  rd_en;
    logic [AW-1:0]         rd_a;

    // Context of the byte being worked off
    logic [7:0]            r_b, n_b;
    logic                  r_last, n_last;
    logic                  r_tok_v, n_tok_v;
    rlpd_pkg::t_kind       r_tok_kind, n_tok_kind;
    logic                  r_st_v, n_st_v;
    rlpd_pkg::t_kind       r_st_kind, n_st_kind;
    logic [31:0]           r_st_len, n_st_len;
    logic [3:0]            r_depth0, n_depth0;
    rlpd_pkg::t_err        r_err, n_err;
    logic [LEN_BITS:0]     r_nxt, n_nxt;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_done, n_done;

    // Decode of the incoming byte
    logic [7:0]            b;
    logic                  c_single, c_sstr, c_lstr, c_slist, c_llist;
    logic [3:0]            ll;
    logic [3:0]            len_dec;
    logic [LEN_BITS-1:0]   acc_new;
    logic [LEN_BITS-1:0]   a_len;
    logic [LEN_BITS:0]     sum;
    logic [LEN_BITS:0]     d_nxt;
    logic                  fits, over;
    logic                  s_req, s_list;
    rlpd_pkg::t_phase      d_phase;
    rlpd_pkg::t_err        d_err;
    logic                  d_tok_v;
    rlpd_pkg::t_kind       d_tok_kind;
    logic                  d_st_v;
    rlpd_pkg::t_kind       d_st_kind;
    logic                  d_push;
    logic                  d_is_list;
    logic [3:0]            d_len_left;
    logic [LEN_BITS-1:0]   d_acc;
    logic [LEN_BITS-1:0]   d_str_end;

    // Sequencer helpers
    logic                  cap;
    logic                  adv;
    logic                  pop_hit;

    function automatic rlpd_pkg::t_op mk_rec(rlpd_pkg::t_kind k, logic [7:0] bv,
                                             logic [3:0] dep, logic [31:0] len,
                                             rlpd_pkg::t_err e);
        rlpd_pkg::t_op r;
        r = '0;
        r.item.kind        = k;
        r.item.byte_value  = bv;
        r.item.nest_depth  = dep;
        r.item.item_length = len;
        r.item.error_code  = e;
        return r;
    endfunction

    // Classify the byte against the current phase
    always_comb begin
        b        = i_data.data_byte;
        c_single = (b <= rlpd_pkg::BYTE_MAX);
        c_sstr   = (b > rlpd_pkg::BYTE_MAX) && (b <= rlpd_pkg::STR_SHORT_MAX);
        c_lstr   = (b > rlpd_pkg::STR_SHORT_MAX) && (b <= rlpd_pkg::STR_LONG_MAX);
        c_slist  = (b >= rlpd_pkg::LIST_BASE) && (b <= rlpd_pkg::LIST_SHORT_MAX);
        c_llist  = (b > rlpd_pkg::LIST_SHORT_MAX);
        ll       = c_llist ? 4'(b - rlpd_pkg::LIST_SHORT_MAX)
                           : 4'(b - rlpd_pkg::STR_SHORT_MAX);
        acc_new  = LEN_BITS'({r_acc, b});
        len_dec  = (r_len_left != 4'd0) ? r_len_left - 4'd1 : 4'd0;

        // one length operand feeds the shared end-position adder
        if (r_phase == rlpd_pkg::PH_LENGTH) begin
            a_len = acc_new;
        end else if (c_sstr) begin
            a_len = LEN_BITS'(b - rlpd_pkg::STR_BASE);
        end else if (c_slist) begin
            a_len = LEN_BITS'(b - rlpd_pkg::LIST_BASE);
        end else begin
            a_len = LEN_BITS'(ll);
        end
        sum   = {1'b0, r_pos} + {1'b0, a_len} + (LEN_BITS + 1)'(1);
        d_nxt = {1'b0, r_pos} + (LEN_BITS + 1)'(1);
        fits  = !sum[LEN_BITS];
        over  = (r_open != '0) && (sum[LEN_BITS-1:0] > r_top);

        d_phase    = r_phase;
        d_err      = rlpd_pkg::ERR_NONE;
        d_tok_v    = 1'b0;
        d_tok_kind = rlpd_pkg::K_SINGLE;
        d_st_v     = 1'b0;
        d_st_kind  = rlpd_pkg::K_STR_START;
        d_push     = 1'b0;
        d_is_list  = r_is_list;
        d_len_left = r_len_left;
        d_acc      = r_acc;
        d_str_end  = r_str_end;
        s_req      = 1'b0;
        s_list     = 1'b0;

        unique case (r_phase)
            rlpd_pkg::PH_PREFIX: begin
                if (c_single) begin
                    d_tok_v    = 1'b1;
                    d_tok_kind = rlpd_pkg::K_SINGLE;
                end else if (c_lstr || c_llist) begin
                    if ((ll > 4'(LL_MAX)) || !fits) begin
                        d_err = rlpd_pkg::ERR_WIDE;
                    end else if (over) begin
                        d_err = rlpd_pkg::ERR_OVERRUN;
                    end else begin
                        d_phase    = rlpd_pkg::PH_LENGTH;
                        d_is_list  = c_llist;
                        d_len_left = ll;
                        d_acc      = '0;
                    end
                end else begin
                    s_req  = 1'b1;
                    s_list = c_slist;
                end
            end
            rlpd_pkg::PH_LENGTH: begin
                d_tok_v    = 1'b1;
                d_tok_kind = rlpd_pkg::K_LEN_BYTE;
                d_acc      = acc_new;
                d_len_left = len_dec;
                if (len_dec == 4'd0) begin
                    s_req  = 1'b1;
                    s_list = r_is_list;
                end
            end
            rlpd_pkg::PH_PAYLOAD: begin
                d_tok_v    = 1'b1;
                d_tok_kind = rlpd_pkg::K_PAYLOAD;
                if ({1'b0, r_str_end} <= d_nxt) begin
                    d_phase = rlpd_pkg::PH_PREFIX;
                end
            end
            rlpd_pkg::PH_DONE: begin
                d_tok_v    = 1'b1;
                d_tok_kind = rlpd_pkg::K_TRAILING;
            end
            default: begin
                d_phase = rlpd_pkg::PH_ABSORB;
            end
        endcase

        // start a string or list once its length is known
        if (s_req) begin
            if (s_list && (r_open >= OW'(MAX_DEPTH))) begin
                d_err = rlpd_pkg::ERR_DEEP;
            end else if (!fits) begin
                d_err = rlpd_pkg::ERR_WIDE;
            end else if (over) begin
                d_err = rlpd_pkg::ERR_OVERRUN;
            end else if (s_list) begin
                d_st_v    = 1'b1;
                d_st_kind = rlpd_pkg::K_LIST_START;
                d_push    = 1'b1;
                d_phase   = rlpd_pkg::PH_PREFIX;
            end else begin
                d_st_v    = 1'b1;
                d_st_kind = rlpd_pkg::K_STR_START;
                if (a_len == '0) begin
                    d_phase = rlpd_pkg::PH_PREFIX;
                end else begin
                    d_str_end = sum[LEN_BITS-1:0];
                    d_phase   = rlpd_pkg::PH_PAYLOAD;
                end
            end
        end

        if (d_err != rlpd_pkg::ERR_NONE) begin
            d_phase = rlpd_pkg::PH_ABSORB;
        end
    end

    assign cap     = (r_cnt >= CW'(rlpd_pkg::MAX_RES));
    assign adv     = cap || !i_q_full;
    assign pop_hit = (r_open != '0) && ({1'b0, r_top} == r_nxt);

    // Sequencer: at most one record per cycle into the queue, holding while it is full
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_is_list  = r_is_list;
        n_len_left = r_len_left;
        n_acc      = r_acc;
        n_str_end  = r_str_end;
        n_pos      = r_pos;
        n_open     = r_open;
        n_top      = r_top;
        n_b        = r_b;
        n_last     = r_last;
        n_tok_v    = r_tok_v;
        n_tok_kind = r_tok_kind;
        n_st_v     = r_st_v;
        n_st_kind  = r_st_kind;
        n_st_len   = r_st_len;
        n_depth0   = r_depth0;
        n_err      = r_err;
        n_nxt      = r_nxt;
        n_cnt      = r_cnt;
        n_done     = r_done;
        o_stall    = 1'b1;
        o_q_wr     = 1'b0;
        o_q_data   = '0;
        mem_we     = 1'b0;
        mem_wa     = AW'(r_open);
        rd_en      = 1'b0;
        rd_a       = AW'({1'b0, r_open} - (OW + 1)'(2));

        unique case (r_state)
            rlpd_pkg::FS_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_b        = b;
                    n_last     = i_data.frame_last;
                    n_tok_v    = d_tok_v;
                    n_tok_kind = d_tok_kind;
                    n_st_v     = d_st_v;
                    n_st_kind  = d_st_kind;
                    n_st_len   = 32'(a_len);
                    n_depth0   = 4'(r_open);
                    n_err      = d_err;
                    n_nxt      = d_nxt;
                    n_cnt      = '0;
                    n_done     = 1'b0;
                    n_phase    = d_phase;
                    n_is_list  = d_is_list;
                    n_len_left = d_len_left;
                    n_acc      = d_acc;
                    n_str_end  = d_str_end;
                    n_pos      = (r_pos != POS_MAX) ? r_pos + LEN_BITS'(1) : r_pos;
                    // push the new list's end position
                    if (d_push) begin
                        mem_we = 1'b1;
                        n_top  = sum[LEN_BITS-1:0];
                        n_open = r_open + OW'(1);
                    end
                    n_state = rlpd_pkg::FS_TOK;
                end
            end
            rlpd_pkg::FS_TOK: begin
                if (!r_tok_v || adv) begin
                    if (r_tok_v && !cap) begin
                        o_q_wr   = 1'b1;
                        o_q_data = mk_rec(r_tok_kind, r_b, r_depth0, 32'd0,
                                          rlpd_pkg::ERR_NONE);
                        n_cnt    = r_cnt + CW'(1);
                    end
                    n_state = rlpd_pkg::FS_START;
                end
            end
            rlpd_pkg::FS_START: begin
                if (!r_st_v || adv) begin
                    if (r_st_v && !cap) begin
                        o_q_wr   = 1'b1;
                        o_q_data = mk_rec(r_st_kind, r_b, r_depth0, r_st_len,
                                          rlpd_pkg::ERR_NONE);
                        n_cnt    = r_cnt + CW'(1);
                    end
                    n_state = rlpd_pkg::FS_ERR;
                end
            end
            rlpd_pkg::FS_ERR: begin
                if (r_err == rlpd_pkg::ERR_NONE) begin
                    n_state = (r_phase == rlpd_pkg::PH_PREFIX) ? rlpd_pkg::FS_POP
                                                               : rlpd_pkg::FS_TAIL;
                end else if (adv) begin
                    if (!cap) begin
                        o_q_wr   = 1'b1;
                        o_q_data = mk_rec(rlpd_pkg::K_ERROR, r_b, 4'(r_open), 32'd0, r_err);
                        n_cnt    = r_cnt + CW'(1);
                    end
                    n_state = rlpd_pkg::FS_TAIL;
                end
            end
            rlpd_pkg::FS_POP: begin
                // close one list per pass while its end is this position
                if (pop_hit) begin
                    if (adv) begin
                        if (!cap) begin
                            o_q_wr   = 1'b1;
                            o_q_data = mk_rec(rlpd_pkg::K_LIST_END, r_b,
                                              4'(r_open - OW'(1)), 32'd0,
                                              rlpd_pkg::ERR_NONE);
                            n_cnt    = r_cnt + CW'(1);
                        end
                        n_open = r_open - OW'(1);
                        rd_en  = ({1'b0, r_open} >= (OW + 1)'(2));
                        n_state = rlpd_pkg::FS_LOAD;
                    end
                end else begin
                    if (r_open == '0) begin
                        n_phase = rlpd_pkg::PH_DONE;
                    end
                    n_state = rlpd_pkg::FS_TAIL;
                end
            end
            rlpd_pkg::FS_LOAD: begin
                n_top   = r_rd;
                n_state = rlpd_pkg::FS_POP;
            end
            rlpd_pkg::FS_TAIL: begin
                if (!r_last) begin
                    n_state = rlpd_pkg::FS_END;
                end else if ((r_phase == rlpd_pkg::PH_DONE) ||
                             (r_phase == rlpd_pkg::PH_ABSORB) || adv) begin
                    // frame ended early unless the item is complete or dropped
                    if ((r_phase != rlpd_pkg::PH_DONE) &&
                        (r_phase != rlpd_pkg::PH_ABSORB) && !cap) begin
                        o_q_wr   = 1'b1;
                        o_q_data = mk_rec(rlpd_pkg::K_ERROR, r_b, 4'(r_open), 32'd0,
                                          rlpd_pkg::ERR_SHORT);
                        n_cnt    = r_cnt + CW'(1);
                    end
                    n_done     = (r_phase == rlpd_pkg::PH_DONE);
                    n_phase    = rlpd_pkg::PH_PREFIX;
                    n_is_list  = 1'b0;
                    n_len_left = 4'd0;
                    n_acc      = '0;
                    n_str_end  = '0;
                    n_pos      = '0;
                    n_open     = '0;
                    n_state    = rlpd_pkg::FS_END;
                end
            end
            rlpd_pkg::FS_END: begin
                if (!i_q_full) begin
                    o_q_wr            = 1'b1;
                    o_q_data          = '0;
                    o_q_data.step_end = 1'b1;
                    o_q_data.done     = r_done;
                    n_state           = rlpd_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = rlpd_pkg::FS_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rlpd_pkg::FS_IDLE;
            r_phase    <= rlpd_pkg::PH_PREFIX;
            r_is_list  <= 1'b0;
            r_len_left <= 4'd0;
            r_acc      <= '0;
            r_str_end  <= '0;
            r_pos      <= '0;
            r_open     <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_is_list  <= n_is_list;
            r_len_left <= n_len_left;
            r_acc      <= n_acc;
            r_str_end  <= n_str_end;
            r_pos      <= n_pos;
            r_open     <= n_open;
        end
    end

    // Byte context and top-of-stack cache
    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_b        <= n_b;
        r_last     <= n_last;
        r_tok_v    <= n_tok_v;
        r_tok_kind <= n_tok_kind;
        r_st_v     <= n_st_v;
        r_st_kind  <= n_st_kind;
        r_st_len   <= n_st_len;
        r_depth0   <= n_depth0;
        r_err      <= n_err;
        r_nxt      <= n_nxt;
        r_cnt      <= n_cnt;
        r_done     <= n_done;
    end

    // List end stack: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_wa] <= sum[LEN_BITS-1:0];
        end
        if (rd_en) begin
            r_rd <= r_stack[rd_a];
        end
    end

endmodule

// File: hw/rtl/rlpd_fifo.sv
// Short record queue between the decoder front and back.
`timescale 1ns / 1ps

module rlpd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  rlpd_pkg::t_op i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output rlpd_pkg::t_op o_rdata,
    output logic          o_empty
);

    localparam int PW = $clog2(rlpd_pkg::Q_DEPTH);
    localparam int CW = $clog2(rlpd_pkg::Q_DEPTH + 1);

    rlpd_pkg::t_op r_mem [rlpd_pkg::Q_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(rlpd_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wp  = do_wr ? r_wp + PW'(1) : r_wp;
        n_rp  = do_rd ? r_rp + PW'(1) : r_rp;
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: hw/rtl/rlpd_back.sv
// Back of the RLP decoder: flags each byte's final result and drives the output register.
`timescale 1ns / 1ps

module rlpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlpd_pkg::t_op       i_q_data,
    input  logic                i_q_empty,
    output logic                o_q_rd,
    output logic                o_valid,
    input  logic                i_stall,
    output rlpd_pkg::t_out_item o_data
);

    logic                r_hold_v, n_hold_v;
    rlpd_pkg::t_out_item r_hold, n_hold;
    logic                r_out_v, n_out_v;
    rlpd_pkg::t_out_item r_out, n_out;
    logic                out_free;
    logic                load;

    assign out_free = !r_out_v || !i_stall;
    assign o_valid  = r_out_v;
    assign o_data   = r_out;

    // Hold one result back until the next record shows whether it was the last
    always_comb begin
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_out    = r_out;
        o_q_rd   = 1'b0;
        load     = 1'b0;
        if (!i_q_empty) begin
            if (!r_hold_v) begin
                o_q_rd = 1'b1;
                if (!i_q_data.step_end) begin
                    n_hold   = i_q_data.item;
                    n_hold_v = 1'b1;
                end
            end else if (out_free) begin
                o_q_rd = 1'b1;
                load   = 1'b1;
                n_out  = r_hold;
                if (i_q_data.step_end) begin
                    n_out.last_result = 1'b1;
                    n_out.frame_done  = i_q_data.done;
                    n_hold_v          = 1'b0;
                end else begin
                    n_hold = i_q_data.item;
                end
            end
        end
        n_out_v = load ? 1'b1 : (out_free ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

endmodule

// File: tb/tb_rlp_stream_decoder.sv
// Self-checking testbench for the RLP stream decoder: directed frames, then random frames.
`timescale 1ns / 1ps

module tb_rlp_stream_decoder;

    localparam int DEPTH = rlpd_pkg::MAX_DEPTH_DEF;
    localparam int LBITS = rlpd_pkg::LEN_BITS_DEF;
    localparam logic [63:0] POS_MAX = (64'd1 << LBITS) - 64'd1;

    // Bytes to queue in all, directed frames included.
    localparam int N_ITEMS = 370;
    // Overshoot allowed for the last random frame.
    localparam int SLACK = 30;
    // Slowest honest run: ~400 bytes, each with its longest idle gap, its decoder pass and
    // ten tokens under the longest receiver stalls, plus the long hold: well inside the limit.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef logic [7:0] t_byte_q[$];

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    rlpd_pkg::t_in_item  i_data = '0;
    logic                o_stall;
    logic                o_valid;
    rlpd_pkg::t_out_item o_data;

    rlpd_pkg::t_in_item  byte_q[$];
    rlpd_pkg::t_out_item token_q[$];
    rlpd_pkg::t_out_item step_tokens[$];

    int n_err = 0;
    int n_in = 0;
    int n_queued = 0;
    int n_cyc = 0;
    int gap_left = 0;
    int calm_left = 0;
    int hold_left = 0;
    int run_left = 0;
    logic hold_done = 1'b0;

    // Decoder state as the predictor sees it.
    rlpd_pkg::t_phase dec_phase = rlpd_pkg::PH_PREFIX;
    logic             hdr_is_list = 1'b0;
    int unsigned      len_left = 0;
    logic [63:0]      len_acc = '0;
    logic [63:0]      str_end = '0;
    logic [63:0]      frame_pos = '0;
    int unsigned      open_cnt = 0;
    logic [63:0]      end_stack[DEPTH];

    rlp_stream_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // Append one token for the current byte, dropping any beyond the cap.
    function automatic void emit_tok(rlpd_pkg::t_kind k, logic [7:0] b, logic [63:0] len,
                                     rlpd_pkg::t_err e);
        rlpd_pkg::t_out_item r;
        if (step_tokens.size() >= rlpd_pkg::MAX_RES) return;
        r.kind        = k;
        r.byte_value  = b;
        r.nest_depth  = open_cnt[3:0];
        r.item_length = len[31:0];
        r.error_code  = e;
        r.frame_done  = 1'b0;
        r.last_result = 1'b0;
        step_tokens = {step_tokens, r};
    endfunction

    // An item of len bytes after position p still ends inside the position range.
    function automatic logic end_in_range(logic [63:0] p, logic [63:0] len);
        return (p < POS_MAX) && (len <= POS_MAX - (p + 64'd1));
    endfunction

    function automatic logic past_parent(logic [63:0] stop);
        if (open_cnt == 0) return 1'b0;
        if (open_cnt - 1 >= DEPTH) return 1'b1;
        return stop > end_stack[open_cnt - 1];
    endfunction

    function automatic void clear_frame();
        dec_phase   = rlpd_pkg::PH_PREFIX;
        hdr_is_list = 1'b0;
        len_left    = 0;
        len_acc     = '0;
        str_end     = '0;
        frame_pos   = '0;
        open_cnt    = 0;
    endfunction

    // Open a string or list once its length is known.
    function automatic rlpd_pkg::t_err open_item(logic is_list, logic [63:0] p,
                                                 logic [7:0] b, logic [63:0] len);
        logic [63:0] stop;
        stop = p + 64'd1 + len;
        if (is_list && open_cnt >= DEPTH) return rlpd_pkg::ERR_DEEP;
        if (!end_in_range(p, len)) return rlpd_pkg::ERR_WIDE;
        if (past_parent(stop)) return rlpd_pkg::ERR_OVERRUN;
        if (is_list) begin
            emit_tok(rlpd_pkg::K_LIST_START, b, len, rlpd_pkg::ERR_NONE);
            end_stack[open_cnt] = stop;
            open_cnt++;
            dec_phase = rlpd_pkg::PH_PREFIX;
        end else begin
            emit_tok(rlpd_pkg::K_STR_START, b, len, rlpd_pkg::ERR_NONE);
            if (len == 0) begin
                dec_phase = rlpd_pkg::PH_PREFIX;
            end else begin
                str_end = stop;
                dec_phase = rlpd_pkg::PH_PAYLOAD;
            end
        end
        return rlpd_pkg::ERR_NONE;
    endfunction

    // Predict the tokens of one transferred byte and queue them; return their number.
    function automatic int decode_byte(rlpd_pkg::t_in_item it);
        logic [7:0]     b;
        logic           is_last;
        logic [63:0]    p;
        logic [63:0]    nxt;
        logic [63:0]    ll;
        logic           is_list;
        rlpd_pkg::t_err err;
        logic           done_ok;
        b       = it.data_byte;
        is_last = it.frame_last;
        p       = frame_pos;
        nxt     = p + 64'd1;
        err     = rlpd_pkg::ERR_NONE;
        done_ok = 1'b0;
        step_tokens.delete();

        case (dec_phase)
            rlpd_pkg::PH_PREFIX: begin
                if (b <= rlpd_pkg::BYTE_MAX) begin
                    emit_tok(rlpd_pkg::K_SINGLE, b, 64'd0, rlpd_pkg::ERR_NONE);
                end else if (b <= rlpd_pkg::STR_SHORT_MAX) begin
                    err = open_item(1'b0, p, b, 64'(b - rlpd_pkg::STR_BASE));
                end else if (b <= rlpd_pkg::STR_LONG_MAX || b > rlpd_pkg::LIST_SHORT_MAX) begin
                    is_list = b > rlpd_pkg::LIST_SHORT_MAX;
                    ll = is_list ? 64'(b - rlpd_pkg::LIST_SHORT_MAX)
                                 : 64'(b - rlpd_pkg::STR_SHORT_MAX);
                    if (ll * 8 > LBITS || !end_in_range(p, ll)) begin
                        err = rlpd_pkg::ERR_WIDE;
                    end else if (past_parent(nxt + ll)) begin
                        err = rlpd_pkg::ERR_OVERRUN;
                    end else begin
                        hdr_is_list = is_list;
                        len_left    = 32'(ll);
                        len_acc     = '0;
                        dec_phase   = rlpd_pkg::PH_LENGTH;
                    end
                end else begin
                    err = open_item(1'b1, p, b, 64'(b - rlpd_pkg::LIST_BASE));
                end
            end
            rlpd_pkg::PH_LENGTH: begin
                emit_tok(rlpd_pkg::K_LEN_BYTE, b, 64'd0, rlpd_pkg::ERR_NONE);
                len_acc = ((len_acc << 8) | 64'(b)) & POS_MAX;
                if (len_left > 0) len_left--;
                if (len_left == 0) err = open_item(hdr_is_list, p, b, len_acc);
            end
            rlpd_pkg::PH_PAYLOAD: begin
                emit_tok(rlpd_pkg::K_PAYLOAD, b, 64'd0, rlpd_pkg::ERR_NONE);
                if (nxt >= str_end) dec_phase = rlpd_pkg::PH_PREFIX;
            end
            rlpd_pkg::PH_DONE: begin
                emit_tok(rlpd_pkg::K_TRAILING, b, 64'd0, rlpd_pkg::ERR_NONE);
            end
            default: begin
                dec_phase = rlpd_pkg::PH_ABSORB;
            end
        endcase

        // Report the error, or close every list that ends at this byte.
        if (err != rlpd_pkg::ERR_NONE) begin
            emit_tok(rlpd_pkg::K_ERROR, b, 64'd0, err);
            dec_phase = rlpd_pkg::PH_ABSORB;
        end else if (dec_phase == rlpd_pkg::PH_PREFIX) begin
            while (open_cnt > 0 && open_cnt <= DEPTH && end_stack[open_cnt - 1] == nxt) begin
                open_cnt--;
                emit_tok(rlpd_pkg::K_LIST_END, b, 64'd0, rlpd_pkg::ERR_NONE);
            end
            if (open_cnt == 0) dec_phase = rlpd_pkg::PH_DONE;
        end

        frame_pos = (p < POS_MAX) ? p + 64'd1 : POS_MAX;

        if (is_last) begin
            if (dec_phase == rlpd_pkg::PH_DONE) done_ok = 1'b1;
            else if (dec_phase != rlpd_pkg::PH_ABSORB)
                emit_tok(rlpd_pkg::K_ERROR, b, 64'd0, rlpd_pkg::ERR_SHORT);
            clear_frame();
        end

        // Mark the final token of the byte.
        if (step_tokens.size() > 0) begin
            step_tokens[step_tokens.size() - 1].frame_done  = done_ok;
            step_tokens[step_tokens.size() - 1].last_result = 1'b1;
        end
        token_q = {token_q, step_tokens};
        return step_tokens.size();
    endfunction

    // Idle lengths: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Put a header, short or long, in front of a payload.
    function automatic t_byte_q wrap(logic is_list, t_byte_q pay);
        t_byte_q res;
        int len;
        int ll;
        len = pay.size();
        if (len <= 55 && $urandom_range(0, 7) != 0) begin
            res = {res, 8'((is_list ? rlpd_pkg::LIST_BASE : rlpd_pkg::STR_BASE) + 8'(len))};
        end else begin
            // a leading zero length byte now and then
            ll = ((len > 255) ? 2 : 1) + (($urandom_range(0, 3) == 0) ? 1 : 0);
            res = {res, 8'((is_list ? rlpd_pkg::LIST_SHORT_MAX : rlpd_pkg::STR_SHORT_MAX)
                           + 8'(ll))};
            for (int i = ll - 1; i >= 0; i--) res = {res, 8'(len >> (8 * i))};
        end
        res = {res, pay};
        return res;
    endfunction

    // Well-formed item with random content, lists nested up to lim deep.
    function automatic t_byte_q gen_item(int lvl, int lim);
        t_byte_q pay;
        t_byte_q sub;
        t_byte_q res;
        int sel;
        int n;
        if (lvl < lim && $urandom_range(0, 99) < ((lim >= 5) ? 85 : 50)) begin
            if (lvl < 2) n = $urandom_range(0, 3);
            else n = ($urandom_range(0, 4) == 0) ? 2 : 1;
            repeat (n) begin
                sub = gen_item(lvl + 1, lim);
                pay = {pay, sub};
            end
            return wrap(1'b1, pay);
        end
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            res = {res, 8'($urandom_range(0, 127))};
            return res;
        end
        n = (sel == 9) ? $urandom_range(50, 70) : $urandom_range(0, 5);
        repeat (n) pay = {pay, 8'($urandom)};
        return wrap(1'b0, pay);
    endfunction

    // Mostly well-formed frames; the rest truncated, corrupted, noise or over-long.
    function automatic t_byte_q gen_frame();
        t_byte_q f;
        int sel;
        int lim;
        sel = $urandom_range(0, 99);
        lim = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 3);
        if (sel < 95) f = gen_item(0, lim);
        if (sel < 72) begin
            if ($urandom_range(0, 6) == 0) repeat ($urandom_range(1, 3)) f = {f, 8'($urandom)};
        end else if (sel < 80) begin
            if (f.size() > 1) repeat ($urandom_range(1, f.size() - 1)) void'(f.pop_back());
        end else if (sel < 88) begin
            f[$urandom_range(0, f.size() - 1)] = 8'($urandom);
        end else if (sel < 95) begin
            f.delete();
            repeat ($urandom_range(1, 6)) f = {f, 8'($urandom)};
        end else begin
            f = {f, 8'($urandom_range(0, 1) ? rlpd_pkg::STR_SHORT_MAX + 8'd4
                                            : rlpd_pkg::LIST_SHORT_MAX + 8'd4)};
            repeat (4) f = {f, 8'hFF};
        end
        return f;
    endfunction

    function automatic void queue_frame(t_byte_q f);
        rlpd_pkg::t_in_item it;
        foreach (f[i]) begin
            it.data_byte  = f[i];
            it.frame_last = (i == f.size() - 1);
            byte_q = {byte_q, it};
        end
        n_queued += f.size();
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    // Sender: offer queued bytes, hold a stalled transfer, predict on acceptance.
    always @(posedge i_clk) begin : tx_drive
        logic taken;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            if (taken) begin
                n_in++;
                void'(decode_byte(i_data));
            end
            if (!i_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    i_data  <= byte_q.pop_front();
                    i_valid <= 1'b1;
                    if (calm_left > 0) begin
                        calm_left--;
                    end else if ($urandom_range(0, 49) == 0) begin
                        calm_left = $urandom_range(20, 60);
                    end else begin
                        gap_left = gap_len();
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing: random stalls, calm stretches and one long hold-off.
    always @(posedge i_clk) begin : rx_pace
        logic stall_on;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
        end else begin
            if ($urandom_range(0, 29) == 0) begin
                stall_on = 1'b0;
                run_left = $urandom_range(30, 100);
            end else begin
                stall_on = ($urandom_range(0, 99) < 35);
                run_left = stall_on ? gap_len() : $urandom_range(0, 6);
            end
            i_stall <= stall_on;
        end
    end

    // Compare each accepted token with the oldest prediction.
    always @(posedge i_clk) begin : rx_check
        rlpd_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (token_q.size() == 0) begin
                n_err++;
                $display("%0t: token expected none got kind %0d byte %0h", $time,
                         o_data.kind, o_data.byte_value);
            end else begin
                want = token_q.pop_front();
                check_field("kind", want.kind, o_data.kind);
                check_field("byte_value", want.byte_value, o_data.byte_value);
                check_field("nest_depth", want.nest_depth, o_data.nest_depth);
                check_field("item_length", want.item_length, o_data.item_length);
                check_field("error_code", want.error_code, o_data.error_code);
                check_field("frame_done", want.frame_done, o_data.frame_done);
                check_field("last_result", want.last_result, o_data.last_result);
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin : watchdog
        n_cyc++;
        if (n_cyc > CYCLE_LIMIT) begin
            $display("FAIL rlp_stream_decoder");
            $finish;
        end
    end

    initial begin
        t_byte_q f;
        // Directed frames: extremes, long header, each error case.
        f = {8'h00};
        queue_frame(f);
        f = {8'h7F, 8'h01};
        queue_frame(f);
        f = {8'h80};
        queue_frame(f);
        f = {8'hFF, 8'h12};
        queue_frame(f);
        f = {8'hB8, 8'h02, 8'hAA, 8'hBB};
        queue_frame(f);
        f = {8'h83, 8'h01};
        queue_frame(f);
        f = {8'hC2, 8'h83, 8'h00};
        queue_frame(f);
        f = {8'hC8, 8'hC7, 8'hC6, 8'hC5, 8'hC4, 8'hC3, 8'hC2, 8'hC1, 8'hC0};
        queue_frame(f);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Keep the sender fed until the byte count is reached.
        while (n_queued < N_ITEMS) begin
            if (byte_q.size() < 16) begin
                f = gen_frame();
                // skip a frame that would overshoot the count by far
                if (n_queued + f.size() <= N_ITEMS + SLACK) queue_frame(f);
            end else begin
                @(posedge i_clk);
            end
        end

        // Drain: all bytes taken, all tokens seen, then let the pipeline settle.
        while (byte_q.size() != 0 || i_valid) @(posedge i_clk);
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_err == 0) begin
            $display("PASS rlp_stream_decoder");
        end else begin
            $display("FAIL rlp_stream_decoder");
        end
        $finish;
    end

endmodule
